/* hw/rtl/sha256_message_hasher_top_assert.svh */
// Assertion macros shared by the checker of the SHA-256 message hasher.
// Expects signals clk and rst_n in the scope of use.
`ifndef SHA256_MESSAGE_HASHER_TOP_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_TOP_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define SHA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha256 check failed");
// Next-cycle implication, checked outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 check failed");
`endif

/* hw/rtl/sha256_pkg.sv */
// Package of the SHA-256 message hasher: state codes, command and status
// structs, round constants and initial hash values. No dependencies.
`default_nettype none
package sha256_pkg;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [2:0] WORD_LAST = 3'd7;
  localparam logic [5:0] ROUND_LAST = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD80, ST_PADZERO, ST_PADLEN, ST_COMP, ST_FIN, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG, SEL_PAD80, SEL_ZERO, SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t sel;
    logic [2:0] len_idx;
    logic      cnt_inc;
    logic      start;
    logic      round_en;
    logic [5:0] round;
    logic      fin;
    logic [2:0] out_idx;
    logic      restart;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha256_ctrl.sv */
// Controller of the SHA-256 hasher: sequences byte intake, padding,
// compression rounds and digest output. Uses sha256_pkg.
`default_nettype none
module sha256_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_has_byte,
  input  wire logic             in_eom,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_last,
  input  wire sha256_pkg::status_t sts,
  output sha256_pkg::cmd_t      cmd
);

  sha256_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0] round_r, round_nxt;
  logic [2:0] len_r, len_nxt;
  logic [2:0] oidx_r, oidx_nxt;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256_pkg::ST_IDLE;
      ret_r   <= sha256_pkg::ST_IDLE;
      round_r <= '0;
      len_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      round_r <= round_nxt;
      len_r   <= len_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    round_nxt = round_r;
    len_nxt   = len_r;
    oidx_nxt  = oidx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = (oidx_r == sha256_pkg::WORD_LAST);
    cmd       = '0;
    cmd.sel   = sha256_pkg::SEL_MSG;
    cmd.len_idx = len_r;
    cmd.round   = round_r;
    cmd.out_idx = oidx_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push    = in_has_byte;
          cmd.cnt_inc = in_has_byte;
          if (in_has_byte && sts.fill == sha256_pkg::FILL_LAST) begin
            cmd.start = 1'b1;
            round_nxt = '0;
            state_nxt = sha256_pkg::ST_COMP;
            ret_nxt   = in_eom ? sha256_pkg::ST_PAD80 : sha256_pkg::ST_IDLE;
          end else if (in_eom) begin
            state_nxt = sha256_pkg::ST_PAD80;
          end
        end
      end
      sha256_pkg::ST_PAD80: begin
        cmd.push = 1'b1;
        cmd.sel  = sha256_pkg::SEL_PAD80;
        state_nxt = sha256_pkg::ST_PADZERO;
        if (sts.fill == sha256_pkg::FILL_LAST) begin
          cmd.start = 1'b1;
          round_nxt = '0;
          state_nxt = sha256_pkg::ST_COMP;
          ret_nxt   = sha256_pkg::ST_PADZERO;
        end
      end
      sha256_pkg::ST_PADZERO: begin
        if (sts.fill == sha256_pkg::LEN_POS) begin
          len_nxt   = '0;
          state_nxt = sha256_pkg::ST_PADLEN;
        end else begin
          cmd.push = 1'b1;
          cmd.sel  = sha256_pkg::SEL_ZERO;
          if (sts.fill == sha256_pkg::FILL_LAST) begin
            cmd.start = 1'b1;
            round_nxt = '0;
            state_nxt = sha256_pkg::ST_COMP;
            ret_nxt   = sha256_pkg::ST_PADZERO;
          end
        end
      end
      sha256_pkg::ST_PADLEN: begin
        cmd.push = 1'b1;
        cmd.sel  = sha256_pkg::SEL_LEN;
        len_nxt  = len_r + 3'd1;
        if (len_r == sha256_pkg::WORD_LAST) begin
          cmd.start = 1'b1;
          round_nxt = '0;
          state_nxt = sha256_pkg::ST_COMP;
          ret_nxt   = sha256_pkg::ST_OUT;
        end
      end
      sha256_pkg::ST_COMP: begin
        cmd.round_en = 1'b1;
        round_nxt = round_r + 6'd1;
        if (round_r == sha256_pkg::ROUND_LAST) begin
          state_nxt = sha256_pkg::ST_FIN;
        end
      end
      sha256_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        oidx_nxt  = '0;
        state_nxt = ret_r;
      end
      sha256_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == sha256_pkg::WORD_LAST) begin
            cmd.restart = 1'b1;
            state_nxt   = sha256_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/sha256_datapath.sv */
// Datapath of the SHA-256 hasher: word assembly, 16-word schedule window,
// round unit, chaining words and counters. Uses sha256_pkg.
`default_nettype none
module sha256_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sha256_pkg::cmd_t cmd,
  input  wire logic [7:0]       in_byte,
  output sha256_pkg::status_t   sts,
  output logic [31:0]           digest_word
);

  logic [5:0]  fill_r;
  logic [60:0] count_r;
  logic [23:0] part_r;
  logic [31:0] w_r [16];
  logic [31:0] s_r [8];
  logic [31:0] chain_r [8];
  logic [7:0]  byte_mux;
  logic [63:0] bits;
  logic [31:0] w_sched, a, e, t1, t2, w_new;
  logic        word_done;

  assign bits = {count_r, 3'b000};
  assign sts.fill = fill_r;
  assign digest_word = chain_r[cmd.out_idx];

  // Pick the byte to push
  always_comb begin
    unique case (cmd.sel)
      sha256_pkg::SEL_MSG:   byte_mux = in_byte;
      sha256_pkg::SEL_PAD80: byte_mux = sha256_pkg::PAD_BYTE;
      sha256_pkg::SEL_ZERO:  byte_mux = 8'h00;
      sha256_pkg::SEL_LEN:   byte_mux = 8'(bits >> {~cmd.len_idx, 3'b000});
      default:               byte_mux = 8'h00;
    endcase
  end

  // One round of compression plus the next schedule word
  always_comb begin
    a = s_r[0];
    e = s_r[4];
    t1 = s_r[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^
         sha256_pkg::rotr(e, 25)) + ((e & s_r[5]) ^ (~e & s_r[6])) +
         sha256_pkg::ROUND_K[cmd.round] + w_r[0];
    t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22)) +
         ((a & s_r[1]) ^ (a & s_r[2]) ^ (s_r[1] & s_r[2]));
    w_sched = w_r[0] + (sha256_pkg::rotr(w_r[1], 7) ^ sha256_pkg::rotr(w_r[1], 18) ^
              (w_r[1] >> 3)) + w_r[9] + (sha256_pkg::rotr(w_r[14], 17) ^
              sha256_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10));
    word_done = cmd.push && (fill_r[1:0] == 2'b11);
    w_new = cmd.round_en ? w_sched : {part_r, byte_mux};
  end

  // Advance counters and the chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      count_r <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= sha256_pkg::INIT_H[i];
    end else begin
      if (cmd.push) fill_r <= fill_r + 6'd1;
      if (cmd.restart) begin
        count_r <= '0;
        for (int i = 0; i < 8; i++) chain_r[i] <= sha256_pkg::INIT_H[i];
      end else begin
        if (cmd.cnt_inc) count_r <= count_r + 61'd1;
        if (cmd.fin) begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + s_r[i];
        end
      end
    end
  end

  // Shift bytes into words, words into the schedule window; run rounds
  always_ff @(posedge clk) begin
    if (cmd.push) part_r <= {part_r[15:0], byte_mux};
    if (word_done || cmd.round_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) s_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      s_r[7] <= s_r[6];
      s_r[6] <= s_r[5];
      s_r[5] <= s_r[4];
      s_r[4] <= s_r[3] + t1;
      s_r[3] <= s_r[2];
      s_r[2] <= s_r[1];
      s_r[1] <= s_r[0];
      s_r[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sha256_message_hasher_top.sv */
// Top level of the SHA-256 message hasher: stream ports around the
// controller and datapath. Uses sha256_pkg, sha256_ctrl, sha256_datapath.
//
// Usage:
//   Input stream: one request per message byte; in_tuser flags a byte,
//   in_tlast ends the message (with or without a byte, so an empty
//   message is a bare end mark).
//   Output stream: eight 32-bit digest words per message, index in
//   out_tuser (0 is most significant), out_tlast on the eighth word.
//   Flow: each full 64-byte block is compressed by 64 rounds of the single
//   round unit plus the final add, during which in_tready is low. At end
//   of message padding feeds one byte per cycle, pausing while a block is
//   compressed and before the length bytes, and takes one more block when
//   the length spills; the last block is compressed the same way, then the
//   words appear one per cycle while the receiver is ready.
//   The input is stalled while the digest is delivered; a stalled receiver
//   holds the current word, and the hasher restarts after the last word.
//   Reset: synchronous, active low, loads the initial hash values and
//   clears the byte and fill counts.
`default_nettype none
module sha256_message_hasher_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] message_byte
  input  wire logic        in_tuser,   // [0] has_byte
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast   // last_word
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t sts;

  sha256_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_has_byte(in_tuser), .in_eom(in_tlast),
    .in_ready(in_tready), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_last(out_tlast), .sts, .cmd
  );

  sha256_datapath u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_tdata), .sts, .digest_word(out_tdata)
  );

  assign out_tuser = cmd.out_idx;

endmodule
`default_nettype wire

/* hw/rtl/sha256_checker.sv */
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Uses macros from sha256_message_hasher_top_assert.svh.
`default_nettype none
`include "sha256_message_hasher_top_assert.svh"
module sha256_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // Last word carries the top index
  `SHA_ASSERT_NOW(a_last_idx, out_tvalid && out_tlast, out_tuser == 3'd7)
  // Input is held off while a digest drains
  `SHA_ASSERT_NOW(a_no_in_during_out, out_tvalid, !in_tready)
  // Words follow in index order
  `SHA_ASSERT_NEXT(a_idx_step, out_tvalid && out_tready && !out_tlast,
                   out_tvalid && (out_tuser == 3'($past(out_tuser) + 3'd1)))
  // Digest ends after the last word
  `SHA_ASSERT_NEXT(a_end, out_tvalid && out_tready && out_tlast, !out_tvalid)

endmodule

bind sha256_message_hasher_top sha256_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tuser, .out_tlast
);
`default_nettype wire
